// ===== rtl/stereo_disparity_winner_take_all_defines.svh =====
// Assertion macros shared by the RTL files of the disparity block.
// Both macros expect a clock named clock and a reset named reset in scope.
`ifndef STEREO_DISPARITY_WINNER_TAKE_ALL_DEFINES_SVH
`define STEREO_DISPARITY_WINNER_TAKE_ALL_DEFINES_SVH
`ifndef SYNTHESIS
`define SDWTA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SDWTA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SDWTA_ASSERT(label, prop, msg)
`define SDWTA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/sdwta_pkg.sv =====
package sdwta_pkg;

   localparam int PIX_W         = 8;
   localparam int SHIFT_COUNT_W = 7;
   localparam int ROW_WIDTH_W   = 13;
   localparam int STRETCH_W     = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH   = 1'b1;

   localparam int DEFAULT_SHIFT_COUNT = 16;
   localparam int DEFAULT_ROW_WIDTH   = 640;
   localparam int DEFAULT_MAX_SHIFTS  = 64;
   localparam int DEFAULT_MAX_WIDTH   = 4096;
   localparam int DEFAULT_AGE_W       = $clog2(DEFAULT_MAX_SHIFTS);
   localparam int DEFAULT_SHIFTS_W    = SHIFT_COUNT_W;

   // Full-scale output value; the stretch factor is this divided by the shift count.
   localparam logic [STRETCH_W-1:0] STRETCH_NUM = 8'd255;
   // A fresh pixel starts with the worst possible difference.
   localparam logic [PIX_W-1:0] DIFF_INIT = 8'hFF;

   // Per-item control seen by every cell of the chain.
   typedef struct packed {
      logic             accept;
      logic             shift;
      logic             flush;
      logic [PIX_W-1:0] left_val;
      logic [PIX_W-1:0] right_val;
   } cell_ctl_type;

   // Floored average of three bytes; x/3 equals (x*683)>>11 for all x up to 765.
   function automatic logic [PIX_W-1:0] intensity_of(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] c);
      logic [PIX_W+1:0]  sum;
      logic [PIX_W+12:0] prod;
      sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
      prod = (PIX_W+13)'(sum) * (PIX_W+13)'(683);
      return prod[PIX_W+10:11];
   endfunction

endpackage

// ===== rtl/sdwta_cell.sv =====
module sdwta_cell #(
   parameter int AGE_W = sdwta_pkg::DEFAULT_AGE_W,
   parameter int SHW   = sdwta_pkg::DEFAULT_SHIFTS_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sdwta_pkg::cell_ctl_type      ctl,
   input  logic [SHW-1:0]               shifts,
   input  logic                         above_valid,
   input  logic                         below_valid,
   input  logic [sdwta_pkg::PIX_W-1:0]  below_intensity,
   input  logic [sdwta_pkg::PIX_W-1:0]  below_best_diff,
   input  logic [AGE_W-1:0]             below_age,
   input  logic [AGE_W-1:0]             below_best_shift,
   output logic                         valid,
   output logic [sdwta_pkg::PIX_W-1:0]  intensity,
   output logic [sdwta_pkg::PIX_W-1:0]  best_diff,
   output logic [AGE_W-1:0]             age,
   output logic [AGE_W-1:0]             best_shift,
   output logic                         ripe
);
   import sdwta_pkg::*;

   logic               valid_ff, valid_in;
   logic [PIX_W-1:0]   int_ff, int_in;
   logic [PIX_W-1:0]   best_ff, best_in;
   logic [AGE_W-1:0]   age_ff, age_in;
   logic [AGE_W-1:0]   bs_ff, bs_in;

   logic               insert;
   logic [PIX_W-1:0]   cur_int;
   logic [PIX_W-1:0]   cur_best;
   logic [AGE_W-1:0]   cur_age;
   logic [AGE_W-1:0]   cur_bs;
   logic [PIX_W-1:0]   diff;
   logic               better;
   logic [SHW:0]       age_plus;

   // The new pixel lands in the highest empty cell, right under the occupied ones.
   assign insert = ctl.accept && !valid_ff && above_valid;

   always_comb begin
      cur_int  = insert ? ctl.right_val : int_ff;
      cur_best = insert ? DIFF_INIT : best_ff;
      cur_age  = insert ? '0 : age_ff + AGE_W'(1);
      cur_bs   = insert ? '0 : bs_ff;
      diff     = (ctl.left_val > cur_int) ? (ctl.left_val - cur_int)
                                          : (cur_int - ctl.left_val);
      better   = (SHW'(cur_age) < shifts) && (diff < cur_best);
   end

   always_comb begin
      valid_in = valid_ff;
      int_in   = int_ff;
      best_in  = best_ff;
      age_in   = age_ff;
      bs_in    = bs_ff;
      priority if (ctl.shift) begin
         valid_in = below_valid;
         int_in   = below_intensity;
         best_in  = below_best_diff;
         age_in   = below_age;
         bs_in    = below_best_shift;
      end else if (ctl.accept && (valid_ff || insert)) begin
         valid_in = 1'b1;
         int_in   = cur_int;
         age_in   = cur_age;
         best_in  = better ? diff : cur_best;
         bs_in    = better ? cur_age : cur_bs;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      int_ff  <= int_in;
      best_ff <= best_in;
      age_ff  <= age_in;
      bs_ff   <= bs_in;
   end

   assign age_plus = {1'b0, SHW'(age_ff)} + (SHW+1)'(1);
   assign ripe     = valid_ff && ((age_plus >= {1'b0, shifts}) || ctl.flush);

   assign valid      = valid_ff;
   assign intensity  = int_ff;
   assign best_diff  = best_ff;
   assign age        = age_ff;
   assign best_shift = bs_ff;

endmodule

// ===== rtl/sdwta_stretch_div.sv =====
module sdwta_stretch_div #(
   parameter int SHW            = sdwta_pkg::DEFAULT_SHIFTS_W,
   parameter int RESET_QUOTIENT = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SHW-1:0]                   divisor,
   output logic [sdwta_pkg::STRETCH_W-1:0]  quotient,
   output logic                             busy
);
   import sdwta_pkg::*;

   localparam int STEP_W = $clog2(STRETCH_W);

   logic                 busy_ff, busy_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SHW-1:0]       rem_ff, rem_in;
   logic [SHW-1:0]       div_ff, div_in;
   logic [STRETCH_W-1:0] quo_ff, quo_in;

   logic [SHW:0]         rem_sh;
   logic [SHW:0]         rem_next;
   logic                 fits;

   // Restoring division of the constant numerator, one quotient bit per cycle.
   always_comb begin
      rem_sh   = {rem_ff, STRETCH_NUM[step_ff]};
      fits     = rem_sh >= {1'b0, div_ff};
      rem_next = fits ? (rem_sh - {1'b0, div_ff}) : rem_sh;
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      priority if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(STRETCH_W - 1);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_next[SHW-1:0];
         quo_in  = {quo_ff[STRETCH_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != '0);
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         quo_ff  <= STRETCH_W'(RESET_QUOTIENT);
      end else begin
         busy_ff <= busy_in;
         quo_ff  <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;

endmodule

// ===== rtl/stereo_disparity_winner_take_all.sv =====
// Stereo disparity by absolute intensity difference, winner take all. Each
// req transfer carries one column of a stereo pair (left and right RGB bytes);
// each rsp transfer returns the disparity of one right pixel, stretched to the
// full 8-bit range by floor(255 / shift_count), in column order, with row_end
// on the last pixel of a row and last on the final result caused by a req
// transfer. Pending right pixels sit in a chain of MAX_SHIFTS cells, packed at
// the top end, oldest at the top. Every accepted column is compared against
// all pending pixels in parallel in the accept cycle; finished pixels then
// leave through the top cell, one per cycle unless rsp_ready is low, and the
// chain shifts up by one with each result. Sequence: a column is accepted,
// then its finished pixels are shown one after another, and the next column
// is taken only once the last of them is handed over. A write to shift_count
// starts a bit-serial division for the stretch factor, and no column is
// accepted until it ends. No clearing pass runs after reset; the chain is
// empty at once.
`include "stereo_disparity_winner_take_all_defines.svh"

module stereo_disparity_winner_take_all #(
   parameter int MAX_SHIFTS = sdwta_pkg::DEFAULT_MAX_SHIFTS,
   parameter int MAX_WIDTH  = sdwta_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_left_red,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_left_green,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_left_blue,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_right_red,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_right_green,
   input  logic [sdwta_pkg::PIX_W-1:0]         req_right_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sdwta_pkg::PIX_W-1:0]         rsp_disparity,
   output logic                                rsp_row_end,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdwta_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sdwta_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sdwta_pkg::*;

   // Cell count and age width follow from MAX_SHIFTS; the shift-count width from it and SHIFT_COUNT_W.
   localparam int N     = MAX_SHIFTS;
   localparam int TOP   = N - 1;
   localparam int AGE_W = (N > 1) ? $clog2(N) : 1;
   localparam int SHW   = ($clog2(N + 1) > SHIFT_COUNT_W) ? $clog2(N + 1) : SHIFT_COUNT_W;
   // Column counter width follows from MAX_WIDTH; the row-width compare width from it and ROW_WIDTH_W.
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;
   localparam int RESET_SHIFTS =
      (DEFAULT_SHIFT_COUNT > MAX_SHIFTS) ? MAX_SHIFTS : DEFAULT_SHIFT_COUNT;
   localparam int RESET_STRETCH = 255 / RESET_SHIFTS;

   logic [SHIFT_COUNT_W-1:0] shift_count_ff, shift_count_in;
   logic [ROW_WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic [CW-1:0]            col_ff, col_in;
   logic                     drain_ff, drain_in;
   logic                     flush_ff, flush_in;

   logic [SHW-1:0]           eff_shifts;
   logic [SHW-1:0]           new_shifts;
   logic [CMP_W-1:0]         eff_width;
   logic [CMP_W-1:0]         col_next;
   logic                     at_row_end;
   logic                     req_xfer;
   logic                     rsp_xfer;
   logic                     shift_write;
   logic                     div_busy;
   logic [STRETCH_W-1:0]     stretch;
   logic                     top_ripe;
   logic                     next_ripe;
   logic [AGE_W+STRETCH_W-1:0] disp_prod;
   cell_ctl_type             ctl;

   logic [N-1:0]             c_valid_vec;
   logic [N-1:0]             c_ripe;
   logic [PIX_W-1:0]         c_int  [N];
   logic [PIX_W-1:0]         c_best [N];
   logic [AGE_W-1:0]         c_age  [N];
   logic [AGE_W-1:0]         c_bs   [N];
   logic [N-1:0]             bel_valid;
   logic [PIX_W-1:0]         bel_int  [N];
   logic [PIX_W-1:0]         bel_best [N];
   logic [AGE_W-1:0]         bel_age  [N];
   logic [AGE_W-1:0]         bel_bs   [N];
   logic [N-1:0]             abv_valid;
   logic [N-1:0]             free_vec;
   logic [N-1:0]             free_plus;

   // A shift count of zero means one shift; counts beyond the chain saturate.
   function automatic logic [SHW-1:0] clamp_shifts(input logic [SHIFT_COUNT_W-1:0] sc);
      logic [SHW-1:0] wide;
      wide = SHW'(sc);
      priority if (sc == '0) begin
         return SHW'(1);
      end else if (wide > SHW'(MAX_SHIFTS)) begin
         return SHW'(MAX_SHIFTS);
      end else begin
         return wide;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. The port always takes a write; a write of the
   // shift count also starts the stretch-factor division.
   // ---------------------------------------------------------------------
   assign csr_ready   = 1'b1;
   assign shift_write = csr_valid && (csr_index == CSR_SHIFT_COUNT);
   assign new_shifts  = clamp_shifts(csr_data[SHIFT_COUNT_W-1:0]);
   assign eff_shifts  = clamp_shifts(shift_count_ff);

   always_comb begin
      shift_count_in = shift_count_ff;
      row_width_in   = row_width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHIFT_COUNT: shift_count_in = csr_data[SHIFT_COUNT_W-1:0];
            CSR_ROW_WIDTH:   row_width_in   = csr_data[ROW_WIDTH_W-1:0];
            default:         shift_count_in = shift_count_ff;
         endcase
      end
   end

   sdwta_stretch_div #(
      .SHW            (SHW),
      .RESET_QUOTIENT (RESET_STRETCH)
   ) u_stretch_div (
      .clock    (clock),
      .reset    (reset),
      .start    (shift_write),
      .divisor  (new_shifts),
      .quotient (stretch),
      .busy     (div_busy)
   );

   // ---------------------------------------------------------------------
   // Row position. A zero row width means one pixel per row, and widths
   // beyond MAX_WIDTH saturate. A shrunk width ends the row on this column.
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (row_width_ff == '0) begin
         eff_width = CMP_W'(1);
      end else if (CMP_W'(row_width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = CMP_W'(row_width_ff);
      end
      col_next   = CMP_W'(col_ff) + CMP_W'(1);
      at_row_end = col_next >= eff_width;
      col_in     = col_ff;
      if (req_xfer) begin
         col_in = at_row_end ? '0 : col_next[CW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Item control. A column is taken only when the previous one has handed
   // over all its results, the stretch factor is settled, csr_valid is low.
   // ---------------------------------------------------------------------
   assign req_ready = !drain_ff && !div_busy && !csr_valid;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   always_comb begin
      drain_in = drain_ff;
      flush_in = flush_ff;
      priority if (req_xfer) begin
         drain_in = 1'b1;
         flush_in = at_row_end;
      end else if (drain_ff && (!top_ripe || (rsp_xfer && rsp_last))) begin
         drain_in = 1'b0;
         flush_in = 1'b0;
      end else begin
         drain_in = drain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_count_ff <= SHIFT_COUNT_W'(DEFAULT_SHIFT_COUNT);
         row_width_ff   <= ROW_WIDTH_W'(DEFAULT_ROW_WIDTH);
         col_ff         <= '0;
         drain_ff       <= 1'b0;
         flush_ff       <= 1'b0;
      end else begin
         shift_count_ff <= shift_count_in;
         row_width_ff   <= row_width_in;
         col_ff         <= col_in;
         drain_ff       <= drain_in;
         flush_ff       <= flush_in;
      end
   end

   always_comb begin
      ctl.accept    = req_xfer;
      ctl.shift     = rsp_xfer;
      ctl.flush     = flush_ff;
      ctl.left_val  = intensity_of(req_left_red, req_left_green, req_left_blue);
      ctl.right_val = intensity_of(req_right_red, req_right_green, req_right_blue);
   end

   // ---------------------------------------------------------------------
   // Cell chain. Cell 0 is fed an empty slot from below while draining; the
   // top cell sees an occupied neighbor above so that an empty chain takes
   // its first pixel at the top.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < N; k++) begin : g_cell
      if (k == 0) begin : g_bottom
         assign bel_valid[k] = 1'b0;
         assign bel_int[k]   = '0;
         assign bel_best[k]  = DIFF_INIT;
         assign bel_age[k]   = '0;
         assign bel_bs[k]    = '0;
      end else begin : g_link
         assign bel_valid[k] = c_valid_vec[k-1];
         assign bel_int[k]   = c_int[k-1];
         assign bel_best[k]  = c_best[k-1];
         assign bel_age[k]   = c_age[k-1];
         assign bel_bs[k]    = c_bs[k-1];
      end

      if (k == TOP) begin : g_top
         assign abv_valid[k] = 1'b1;
      end else begin : g_under
         assign abv_valid[k] = c_valid_vec[k+1];
      end

      sdwta_cell #(
         .AGE_W (AGE_W),
         .SHW   (SHW)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .ctl              (ctl),
         .shifts           (eff_shifts),
         .above_valid      (abv_valid[k]),
         .below_valid      (bel_valid[k]),
         .below_intensity  (bel_int[k]),
         .below_best_diff  (bel_best[k]),
         .below_age        (bel_age[k]),
         .below_best_shift (bel_bs[k]),
         .valid            (c_valid_vec[k]),
         .intensity        (c_int[k]),
         .best_diff        (c_best[k]),
         .age              (c_age[k]),
         .best_shift       (c_bs[k]),
         .ripe             (c_ripe[k])
      );
   end

   assign top_ripe = c_ripe[TOP];

   if (N > 1) begin : g_next
      assign next_ripe = c_ripe[TOP-1];
   end else begin : g_single
      assign next_ripe = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Result side. The top cell is the output register: its result is shown
   // while finished during a drain; the chain moves up on each rsp transfer.
   // ---------------------------------------------------------------------
   assign disp_prod     = (AGE_W+STRETCH_W)'(c_bs[TOP]) * (AGE_W+STRETCH_W)'(stretch);
   assign rsp_valid     = drain_ff && top_ripe;
   assign rsp_disparity = disp_prod[PIX_W-1:0];
   assign rsp_row_end   = flush_ff && (c_age[TOP] == '0);
   assign rsp_last      = !next_ripe;

   // Occupied cells always form one block at the top of the chain.
   assign free_vec  = ~c_valid_vec;
   assign free_plus = free_vec + N'(1);

   `SDWTA_ASSERT(a_row_end_is_last, (rsp_xfer && rsp_row_end) |-> rsp_last, "row end not last")
   `SDWTA_ASSERT(a_last_ends_drain, (rsp_xfer && rsp_last) |=> !drain_ff, "drain did not end")
   `SDWTA_ASSERT(a_room_for_pixel, !drain_ff |-> !c_valid_vec[0], "no free cell for next pixel")
   `SDWTA_ASSERT(a_cells_packed, (free_vec & free_plus) == '0, "occupied cells not packed")
   `SDWTA_ASSERT(a_flush_empties, (drain_ff && flush_ff && !top_ripe) |-> (c_valid_vec == '0), "row end left pixels")

endmodule
